FILE: rtl/core/single_wire_edge_interval_frame_decoder_unit_macros.svh
// Assertion macros shared by the frame decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SINGLE_WIRE_EDGE_INTERVAL_FRAME_DECODER_UNIT_MACROS_SVH
`define SINGLE_WIRE_EDGE_INTERVAL_FRAME_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWEFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWEFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/swefd_pkg.sv
// Package for the single-wire frame decoder: payload structs, command and phase codes.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package swefd_pkg;

  localparam int FRAME_BITS_DEFAULT = 40;
  localparam int STORE_DEPTH        = 5;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CFG_DATA_W         = 16;
  localparam logic [15:0] THRESHOLD_RESET = 16'd100;
  localparam logic [2:0]  BYTE_MSB        = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_WATCHED_PIN   = 1'b0;
  localparam logic CFG_BIT_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    PH_WAKING     = 3'd0,
    PH_RESP_START = 3'd1,
    PH_RESP_STOP  = 3'd2,
    PH_RECEIVING  = 3'd3,
    PH_RECEIVED   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    OP_IGNORE  = 2'd0,
    OP_EDGE    = 2'd1,
    OP_CONSUME = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    bit_val;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] edge_pin;
    logic [15:0] interval_ticks;
  } in_t;

  typedef struct packed {
    logic       ready_res;
    logic [2:0] phase;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/core/swefd_front.sv
// Front end: holds the configuration registers and classifies each input transaction.
// Depends on swefd_pkg.
`default_nettype none

module swefd_front import swefd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire in_t                   in_data_i,
  output cmd_t                       cmd_o
);

  logic [15:0] pin_q, pin_d;
  logic [15:0] thr_q, thr_d;

  always_comb begin
    pin_d = pin_q;
    thr_d = thr_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WATCHED_PIN:   pin_d = cfg_wdata_i;
        CFG_BIT_THRESHOLD: thr_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q <= '0;
      thr_q <= THRESHOLD_RESET;
    end else begin
      pin_q <= pin_d;
      thr_q <= thr_d;
    end
  end

  // A long interval decodes as a one bit; foreign pins become no-ops.
  always_comb begin
    cmd_o.bit_val = (in_data_i.interval_ticks > thr_q);
    if (in_data_i.kind) begin
      cmd_o.op = OP_CONSUME;
    end else if (in_data_i.edge_pin == pin_q) begin
      cmd_o.op = OP_EDGE;
    end else begin
      cmd_o.op = OP_IGNORE;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/swefd_queue.sv
// Short command queue between the front end and the frame engine.
// Depends on swefd_pkg.
`default_nettype none

module swefd_queue import swefd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      nempty_o,
  output cmd_t      pop_data_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(QUEUE_DEPTH));
  assign nempty_o   = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/swefd_engine.sv
// Frame engine: phase machine, bit assembly, byte store and the result register.
// Depends on swefd_pkg and the assertion macro header.
`default_nettype none
`include "single_wire_edge_interval_frame_decoder_unit_macros.svh"

module swefd_engine import swefd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int CntW = $clog2(FRAME_BITS + 1);

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [7:0]      asm_q, asm_d;
  logic [2:0]      byte_idx_q, byte_idx_d;
  logic [2:0]      bit_pos_q, bit_pos_d;
  logic [7:0]      frame_q [STORE_DEPTH];
  logic [7:0]      frame_d [STORE_DEPTH];
  logic            take_bit;
  logic            frame_done;
  logic            ready_res;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  assign cmd_pop_o  = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign take_bit   = cmd_pop_o && (cmd_i.op == OP_EDGE) && (phase_q == PH_RECEIVING);
  assign cnt_inc    = cnt_q + CntW'(1);
  assign frame_done = (cnt_inc >= CntW'(FRAME_BITS));

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (cmd_pop_o) begin
      case (cmd_i.op)
        OP_CONSUME: begin
          if (phase_q == PH_RECEIVED) phase_d = PH_WAKING;
        end
        OP_EDGE: begin
          case (phase_q)
            PH_WAKING:     phase_d = PH_RESP_START;
            PH_RESP_START: phase_d = PH_RESP_STOP;
            PH_RESP_STOP:  phase_d = PH_RECEIVING;
            PH_RECEIVING: begin
              if (frame_done) phase_d = PH_RECEIVED;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Bit assembly and byte store.
  always_comb begin
    cnt_d      = cnt_q;
    asm_d      = asm_q;
    byte_idx_d = byte_idx_q;
    bit_pos_d  = bit_pos_q;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      frame_d[i] = frame_q[i];
    end
    if (take_bit) begin
      asm_d[BYTE_MSB - bit_pos_q] = cmd_i.bit_val;
      bit_pos_d = bit_pos_q + 3'd1;
      cnt_d     = cnt_inc;
      if (cnt_inc[2:0] == 3'd0) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          if (byte_idx_q == 3'(i)) frame_d[i] = asm_d;
        end
        asm_d      = '0;
        byte_idx_d = byte_idx_q + 3'd1;
        bit_pos_d  = '0;
      end
      if (frame_done) begin
        cnt_d      = '0;
        byte_idx_d = '0;
      end
    end
  end

  // Result of the executed command.
  always_comb begin
    if (cmd_i.op == OP_CONSUME) begin
      ready_res = (phase_q == PH_RECEIVED);
    end else begin
      ready_res = (phase_d == PH_RECEIVED);
    end
    out_d.ready_res  = ready_res;
    out_d.phase      = phase_d;
    out_d.byte_zero  = frame_d[0];
    out_d.byte_one   = frame_d[1];
    out_d.byte_two   = frame_d[2];
    out_d.byte_three = frame_d[3];
    out_d.byte_four  = frame_d[4];
    if (cmd_pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAKING;
      cnt_q       <= '0;
      asm_q       <= '0;
      byte_idx_q  <= '0;
      bit_pos_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        frame_q[i] <= '0;
      end
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      asm_q       <= asm_d;
      byte_idx_q  <= byte_idx_d;
      bit_pos_q   <= bit_pos_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        frame_q[i] <= frame_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SWEFD_ASSERT_NOW(a_cnt_in_range, clk_i, rst_ni, 1'b1, cnt_q < CntW'(FRAME_BITS), "bit counter reached frame length")
  `SWEFD_ASSERT_NOW(a_cnt_idle, clk_i, rst_ni, phase_q != PH_RECEIVING, cnt_q == '0, "bit counter nonzero outside receiving")
  `SWEFD_ASSERT_NOW(a_idx_received, clk_i, rst_ni, phase_q == PH_RECEIVED, byte_idx_q == 3'd0, "byte index not cleared at frame end")
  `SWEFD_ASSERT_NEXT(a_pop_result, clk_i, rst_ni, cmd_pop_o, out_valid_q, "executed command produced no result")

endmodule

`default_nettype wire

FILE: rtl/core/single_wire_edge_interval_frame_decoder_unit.sv
// Top level of the single-wire edge-interval frame decoder.
// Depends on swefd_pkg, swefd_front, swefd_queue and swefd_engine.
//
//   Channel   Direction  Handshake               Payload
//   input     in         in_valid_i / in_stall_o   in_data_i  (in_t)
//   output    out        out_valid_o / out_stall_i out_data_o (out_t)
//   config    in         cfg_we_i, no handshake    cfg_idx_i, cfg_wdata_i
//
// Every input transaction yields exactly one output transaction, after passing through
// the command queue and then the engine's result register. The front end and the engine
// each take one transaction per cycle, so the sustained rate is one transaction per cycle
// while the output is not stalled; the phase and bit registers of the engine set that loop.
// Reset is asynchronous and active low; it clears the phase, counters, the five frame
// bytes and the configuration (watched pin zero, threshold one hundred).
// When the output is stalled the engine holds its result and the two-entry queue absorbs
// new transactions; once it is full, in_stall_o is raised.
`default_nettype none

module single_wire_edge_interval_frame_decoder_unit import swefd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_data_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_nempty;
  logic queue_push;
  logic queue_pop;

  // The front end classifies the transaction against the current configuration, so the
  // queued command no longer depends on the configuration registers.
  swefd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_o       (front_cmd)
  );

  assign in_stall_o = queue_full;
  assign queue_push = in_valid_i && !queue_full;

  swefd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (queue_push),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .nempty_o    (queue_nempty),
    .pop_data_o  (queue_cmd)
  );

  // The engine executes one command whenever its result register is free or being drained.
  swefd_engine #(
    .FRAME_BITS (FRAME_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_nempty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: dv/single_wire_edge_interval_frame_decoder_unit_tb.sv
// Self-checking testbench for the single-wire edge-interval frame decoder.
// Depends on swefd_pkg and single_wire_edge_interval_frame_decoder_unit; needs nothing else.
`default_nettype none

module single_wire_edge_interval_frame_decoder_unit_tb;
  import swefd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Meaning of the kind field of an input transaction.
  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_CONSUME = 1'b1;

  localparam int CLK_HALF_NS   = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 6;       // comfortably above the block's latency
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT   = 500000;

  // Clock, reset and every input of the block start at a known value.
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_idx_i   = CFG_WATCHED_PIN;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  single_wire_edge_interval_frame_decoder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // The testbench's own copy of the decoder: configuration and state.
  logic [15:0] pin_cfg;
  logic [15:0] thr_cfg;
  phase_e      dec_phase;
  int          dec_bit_count;
  logic [7:0]  dec_assembly;
  logic [2:0]  dec_byte_idx;
  logic [2:0]  dec_bit_pos;
  logic [7:0]  dec_store [STORE_DEPTH];

  // Frames expected at the output, oldest first.
  out_t frame_expect_q[$];

  // Idling controls, written by the test tasks and read by the driving processes.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;

  // Bookkeeping for the summary and the verdict.
  int fail_count    = 0;
  int counted_items = 0;
  int total_items   = 0;
  int checked_count = 0;
  int frames_done   = 0;
  int consumed_ok   = 0;
  int cycle_count   = 0;

  // Works out the result of one transaction and moves the copied state on, exactly as
  // the decoder does. Edges from another pin and edges while a frame waits change nothing.
  function automatic out_t decode_step(input in_t item);
    out_t res;
    logic ready;
    if (item.kind == KIND_CONSUME) begin
      ready = (dec_phase == PH_RECEIVED);
      if (ready) begin
        dec_phase = PH_WAKING;
      end
    end else begin
      if (item.edge_pin == pin_cfg) begin
        case (dec_phase)
          PH_WAKING: begin
            dec_phase = PH_RESP_START;
          end
          PH_RESP_START: begin
            dec_phase = PH_RESP_STOP;
          end
          PH_RESP_STOP: begin
            dec_phase = PH_RECEIVING;
          end
          PH_RECEIVING: begin
            // Bits arrive MSB first; an interval equal to the threshold still reads as zero.
            dec_assembly[BYTE_MSB - dec_bit_pos] = (item.interval_ticks > thr_cfg);
            dec_bit_pos   = dec_bit_pos + 3'd1;
            dec_bit_count = dec_bit_count + 1;
            if (dec_bit_count % 8 == 0) begin
              if (dec_byte_idx < STORE_DEPTH) begin
                dec_store[dec_byte_idx] = dec_assembly;
              end
              dec_assembly = '0;
              dec_byte_idx = dec_byte_idx + 3'd1;
              dec_bit_pos  = '0;
            end
            if (dec_bit_count >= FRAME_BITS_DEFAULT) begin
              dec_bit_count = 0;
              dec_byte_idx  = '0;
              dec_phase     = PH_RECEIVED;
            end
          end
          default: begin
          end
        endcase
      end
      ready = (dec_phase == PH_RECEIVED);
    end
    res.ready_res  = ready;
    res.phase      = dec_phase;
    res.byte_zero  = dec_store[0];
    res.byte_one   = dec_store[1];
    res.byte_two   = dec_store[2];
    res.byte_three = dec_store[3];
    res.byte_four  = dec_store[4];
    return res;
  endfunction

  function automatic in_t make_edge(input logic [15:0] pin, input logic [15:0] ticks);
    in_t item;
    item.kind           = KIND_EDGE;
    item.edge_pin       = pin;
    item.interval_ticks = ticks;
    return item;
  endfunction

  // A consume request carries random junk in the unused fields so that their bits toggle.
  function automatic in_t make_consume();
    in_t item;
    item.kind           = KIND_CONSUME;
    item.edge_pin       = 16'($urandom);
    item.interval_ticks = 16'($urandom);
    return item;
  endfunction

  // Offers one transaction, waits for it to be taken and records what it should produce.
  // The sender may idle first; valid is only lowered when a gap is actually inserted, so
  // back-to-back transactions never see valid lowered and raised in the same time step.
  task automatic send_item(input in_t item);
    out_t predicted;
    logic was_received;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= in_t'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    was_received = (dec_phase == PH_RECEIVED);
    predicted = decode_step(item);
    frame_expect_q.push_back(predicted);
    total_items++;
    if (item.kind == KIND_CONSUME || item.edge_pin == pin_cfg) begin
      counted_items++;
    end
    // Only the edge that finishes a frame counts, not stray edges while it waits.
    if (item.kind == KIND_EDGE && predicted.ready_res && !was_received) begin
      frames_done++;
    end
    if (item.kind == KIND_CONSUME && predicted.ready_res) begin
      consumed_ok++;
    end
  endtask

  // Stops offering, then waits until every expected frame has been seen and the pipeline
  // has had time to settle. Called straight after an acceptance, so valid drops at once.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (frame_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes happen only once the block is idle.
  task automatic set_config(input logic [15:0] pin, input logic [15:0] thr);
    drain_outputs();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_WATCHED_PIN;
    cfg_wdata_i <= pin;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BIT_THRESHOLD;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 16'($urandom);
    pin_cfg = pin;
    thr_cfg = thr;
    @(posedge clk_i);
  endtask

  // Picks an interval that lands on the threshold, just above or below it, or at random.
  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(4))
      0:       return thr_cfg;
      1:       return thr_cfg + 16'd1;
      2:       return thr_cfg - 16'd1;
      3:       return 16'($urandom_range(200));
      default: return 16'($urandom);
    endcase
  endfunction

  // Occasional noise: an edge on a foreign pin or an extra consume request.
  task automatic maybe_noise();
    logic [15:0] flip;
    if ($urandom_range(99) < 6) begin
      if ($urandom_range(1) == 0) begin
        flip = 16'($urandom) | 16'h0001 << $urandom_range(15);
        send_item(make_edge(pin_cfg ^ flip, 16'($urandom)));
      end else begin
        send_item(make_consume());
      end
    end
  endtask

  // One well-formed frame with random content: wake-up handshake, forty data edges and
  // usually a consume request. Now and then stray edges arrive while the frame waits, or
  // the consume is left out so that the next frame's edges are ignored.
  task automatic run_frame();
    repeat (3) begin
      maybe_noise();
      send_item(make_edge(pin_cfg, 16'($urandom)));
    end
    repeat (FRAME_BITS_DEFAULT) begin
      maybe_noise();
      send_item(make_edge(pin_cfg, pick_ticks()));
    end
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 3)) send_item(make_edge(pin_cfg, 16'($urandom)));
    end
    if ($urandom_range(99) < 90) begin
      send_item(make_consume());
    end
  endtask

  // Directed opening under the reset configuration: consume with nothing waiting, foreign
  // pins, the wake-up handshake, consume in mid-frame and the interval extremes.
  task automatic test_directed_cases();
    pin_cfg = 16'h0000;
    thr_cfg = THRESHOLD_RESET;
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(make_consume());
    send_item(make_edge(16'hFFFF, 16'hFFFF));
    send_item(make_edge(16'h8001, 16'h0000));
    send_item(make_edge(16'h0000, 16'h0000));
    send_item(make_edge(16'h0000, 16'hFFFF));
    send_item(make_edge(16'h0000, 16'h0000));
    send_item(make_consume());
    send_item(make_edge(16'h0000, 16'd0));
    send_item(make_edge(16'h0000, THRESHOLD_RESET));
    send_item(make_edge(16'h0000, THRESHOLD_RESET + 16'd1));
    send_item(make_edge(16'h0000, 16'hFFFF));
    send_item(make_edge(16'h0001, 16'hFFFF));
    send_item(make_edge(16'h0000, 16'hAAAA));
    send_item(make_edge(16'h0000, 16'h5555));
    drain_outputs();
  endtask

  // Random frames under one register setting and one idling pattern.
  task automatic test_random_frames(input logic [15:0] pin, input logic [15:0] thr,
                                    input int idle_pct, input int hold_pct,
                                    input int item_goal);
    int goal;
    set_config(pin, thr);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    goal = counted_items + item_goal;
    while (counted_items < goal) begin
      run_frame();
    end
    drain_outputs();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so the
  // queue fills and the block has to stall its input.
  task automatic test_output_hold();
    set_config(16'($urandom), 16'($urandom_range(50, 400)));
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req++;
    run_frame();
    run_frame();
    drain_outputs();
  endtask

  // Receiver stall: random per cycle, plus the long hold-off counted here.
  int hold_ack  = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Every accepted output transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_expect_q.size() == 0) begin
        $error("output transaction with no expectation waiting");
        fail_count++;
      end else begin
        exp_res = frame_expect_q.pop_front();
        checked_count++;
        check_field("ready_res", exp_res.ready_res, out_data_o.ready_res);
        check_field("phase", exp_res.phase, out_data_o.phase);
        check_field("byte_zero", exp_res.byte_zero, out_data_o.byte_zero);
        check_field("byte_one", exp_res.byte_one, out_data_o.byte_one);
        check_field("byte_two", exp_res.byte_two, out_data_o.byte_two);
        check_field("byte_three", exp_res.byte_three, out_data_o.byte_three);
        check_field("byte_four", exp_res.byte_four, out_data_o.byte_four);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("single_wire_edge_interval_frame_decoder_unit_tb failed");
      $finish;
    end
  end

  initial begin
    dec_phase     = PH_WAKING;
    dec_bit_count = 0;
    dec_assembly  = '0;
    dec_byte_idx  = '0;
    dec_bit_pos   = '0;
    foreach (dec_store[i]) dec_store[i] = '0;
    pin_cfg = 16'h0000;
    thr_cfg = THRESHOLD_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    // Idling patterns: none, sender gaps, receiver stalls, then both lightly.
    test_random_frames(16'hFFFF, 16'h0000, 0, 0, 160);
    test_random_frames(16'($urandom), 16'hFFFF, 79, 0, 160);
    test_random_frames(16'h0000, 16'($urandom), 0, 79, 160);
    test_random_frames(16'($urandom), THRESHOLD_RESET, 17, 17, 160);
    test_output_hold();

    $display("Covered %0d transactions (%0d not ignored), %0d results checked.",
             total_items, counted_items, checked_count);
    $display("Frames completed: %0d, consumed with data: %0d.", frames_done, consumed_ok);
    if (fail_count == 0) begin
      $display("single_wire_edge_interval_frame_decoder_unit_tb passed");
    end else begin
      $display("single_wire_edge_interval_frame_decoder_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/swefd_pkg.sv
rtl/core/swefd_front.sv
rtl/core/swefd_queue.sv
rtl/core/swefd_engine.sv
rtl/core/single_wire_edge_interval_frame_decoder_unit.sv
dv/single_wire_edge_interval_frame_decoder_unit_tb.sv
